### rtl/bounded_deque_engine_defines.svh
// Assertion macros shared by the deque engine RTL.
// Include-only header; depends on nothing.
`ifndef BOUNDED_DEQUE_ENGINE_DEFINES_SVH
`define BOUNDED_DEQUE_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BDE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define BDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bde_pkg.sv
// Types and codes for the bounded deque engine.
// Used by bde_ctrl, bde_dpath and bounded_deque_engine; no dependencies.
package bde_pkg;

  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [2:0] FUNC_PEEK_FRONT = 3'd4;
  localparam logic [2:0] FUNC_PEEK_BACK  = 3'd5;
  localparam logic [2:0] FUNC_REVERSE    = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_MEM,
    CTRL_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic mem_en;
    logic load_out;
  } ctrl_cmd_t;

endpackage

### rtl/bounded_deque_engine.sv
// Top level of the bounded deque engine: 64-bit double-ended queue in a ring store.
// Depends on bde_pkg, bde_ctrl and bde_dpath.
//
//   channel | valid       | stall        | beat
//   input   | in_valid_i  | in_stall_o   | in_data_i  (in_item_t)
//   output  | out_valid_o | out_stall_i  | out_data_o (out_item_t)
//
// Each operation runs as capture, one ring-store access, then result load.
// The ring store is single-port: one read or write per operation.
// The next beat is accepted while a finished result waits in the output register.
// A stalled output holds the engine in its load step until the result is taken.
// Reset clears head, count and direction; the ring store needs no clearing.
module bounded_deque_engine
  import bde_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  ctrl_cmd_t cmd;

  bde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  bde_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

### rtl/bde_ctrl.sv
// Sequencer for the deque engine: input/output handshakes and datapath commands.
// Depends on bde_pkg and bounded_deque_engine_defines.svh.
`include "bounded_deque_engine_defines.svh"

module bde_ctrl
  import bde_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        out_free;

  assign accept   = in_valid_i && (state_q == CTRL_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTRL_IDLE: if (accept) state_d = CTRL_MEM;
      CTRL_MEM:  state_d = CTRL_LOAD;
      CTRL_LOAD: if (out_free) state_d = CTRL_IDLE;
      default:   state_d = CTRL_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.capture  = accept;
    cmd_o.mem_en   = (state_q == CTRL_MEM);
    cmd_o.load_out = (state_q == CTRL_LOAD) && out_free;
    in_stall_o     = (state_q != CTRL_IDLE);
    out_valid_d    = cmd_o.load_out || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `BDE_ASSERT_NEXT(a_accept_to_mem, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == CTRL_MEM, "accepted beat did not start memory step")
  `BDE_ASSERT_NEXT(a_mem_to_load, clk_i, rst_ni, state_q == CTRL_MEM, state_q == CTRL_LOAD, "memory step not followed by load")
  `BDE_ASSERT_NEXT(a_load_waits, clk_i, rst_ni, state_q == CTRL_LOAD && out_valid_q && out_stall_i, state_q == CTRL_LOAD, "result overwrote a stalled beat")

endmodule

### rtl/bde_dpath.sv
// Datapath of the deque engine: ring store, head/count/direction state, result register.
// Depends on bde_pkg; driven by bde_ctrl commands.
module bde_dpath
  import bde_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  input  in_item_t  in_data_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [63:0]   mem [DEPTH];

  logic [2:0]    func_q;
  logic [63:0]   value_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] occ_q, occ_d;
  logic          rev_q, rev_d;
  logic [63:0]   rdata_q;
  logic          peek_q, peek_d;
  logic [1:0]    status_q, status_d;
  out_item_t     out_q;

  logic          logical_front, phys_front;
  logic          full, empty;
  logic [AW-1:0] head_dec, head_inc;
  logic [SW-1:0] tail_raw, tail_wrap, last_raw, last_wrap;
  logic [AW-1:0] tail_slot, last_slot, slot;
  logic          we;
  logic [31:0]   occ_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= in_data_i.func;
      value_q <= in_data_i.item_value;
    end
  end

  always_comb begin
    logical_front = (func_q == FUNC_PUSH_FRONT) || (func_q == FUNC_POP_FRONT) ||
                    (func_q == FUNC_PEEK_FRONT);
    phys_front = logical_front ^ rev_q;
    full       = (occ_q == CW'(DEPTH));
    empty      = (occ_q == '0);
    head_dec   = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
    head_inc   = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
    tail_raw   = SW'(head_q) + SW'(occ_q);
    tail_wrap  = (tail_raw >= SW'(DEPTH)) ? tail_raw - SW'(DEPTH) : tail_raw;
    tail_slot  = tail_wrap[AW-1:0];
    last_raw   = tail_raw - SW'(1);
    last_wrap  = (last_raw >= SW'(DEPTH)) ? last_raw - SW'(DEPTH) : last_raw;
    last_slot  = last_wrap[AW-1:0];
  end

  always_comb begin
    head_d   = head_q;
    occ_d    = occ_q;
    rev_d    = rev_q;
    status_d = ST_OK;
    peek_d   = 1'b0;
    we       = 1'b0;
    slot     = head_q;
    unique case (func_q)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we    = 1'b1;
          occ_d = occ_q + CW'(1);
          if (phys_front) begin
            head_d = head_dec;
            slot   = head_dec;
          end else begin
            slot = tail_slot;
          end
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          occ_d = occ_q - CW'(1);
          if (phys_front) head_d = head_inc;
        end
      end
      FUNC_PEEK_FRONT, FUNC_PEEK_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          peek_d = 1'b1;
          slot   = phys_front ? head_q : last_slot;
        end
      end
      FUNC_REVERSE: begin
        if (empty) status_d = ST_EMPTY;
        else rev_d = ~rev_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_en) begin
      if (we) mem[slot] <= value_q;
      rdata_q  <= mem[slot];
      peek_q   <= peek_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      occ_q  <= '0;
      rev_q  <= 1'b0;
    end else if (cmd_i.mem_en) begin
      head_q <= head_d;
      occ_q  <= occ_d;
      rev_q  <= rev_d;
    end
  end

  assign occ_ext = 32'(occ_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.read_value  <= peek_q ? rdata_q : '0;
      out_q.entry_count <= occ_ext[4:0];
      out_q.is_empty    <= (occ_q == '0);
      out_q.status      <= status_q;
    end
  end

  assign out_data_o = out_q;

endmodule
